// File: rtl/core/hsps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsps_pkg
// Shared types, element codes and helpers for the HEVC SPS header parser.
// ----------------------------------------------------------------------------
package hsps_pkg;

  localparam int MAX_SUB_LAYERS = 6;
  localparam logic [4:0] MIN_BYTES = 5'd20;
  localparam logic [5:0] MAX_PREFIX_ZEROS = 6'd16;
  localparam logic [3:0] MAX_SPS_ID = 4'd15;
  localparam logic [1:0] MAX_CHROMA = 2'd3;

  localparam logic [5:0] P_VPS      = 6'd0;
  localparam logic [5:0] P_MAXSUB   = 6'd1;
  localparam logic [5:0] P_NEST     = 6'd2;
  localparam logic [5:0] P_PTLHEAD  = 6'd3;
  localparam logic [5:0] P_PROFILE  = 6'd4;
  localparam logic [5:0] P_COMPAT   = 6'd5;
  localparam logic [5:0] P_FLAGS48  = 6'd6;
  localparam logic [5:0] P_LEVEL    = 6'd7;
  localparam logic [5:0] P_SUBFLAGS = 6'd8;
  localparam logic [5:0] P_RESERVED = 6'd9;
  localparam logic [5:0] P_SUBPROFA = 6'd10;
  localparam logic [5:0] P_SUBPROFB = 6'd11;
  localparam logic [5:0] P_SUBLEVEL = 6'd12;
  localparam logic [5:0] P_SPSID    = 6'd13;
  localparam logic [5:0] P_CHROMA   = 6'd14;
  localparam logic [5:0] P_SEP      = 6'd15;
  localparam logic [5:0] P_WIDTH    = 6'd16;
  localparam logic [5:0] P_HEIGHT   = 6'd17;
  localparam logic [5:0] P_CONFFLAG = 6'd18;
  localparam logic [5:0] P_CONF0    = 6'd19;
  localparam logic [5:0] P_DEPTHL   = 6'd23;
  localparam logic [5:0] P_DEPTHC   = 6'd24;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_SUBLAYERS = 3'd2;
  localparam logic [2:0] ST_SPSID     = 3'd3;
  localparam logic [2:0] ST_CHROMA    = 3'd4;
  localparam logic [2:0] ST_DEPTH     = 3'd5;
  localparam logic [2:0] ST_TRUNC     = 3'd6;
  localparam logic [2:0] ST_OVERSIZE  = 3'd7;

  typedef struct packed {
    logic [5:0]  pos;
    logic [5:0]  fbl;
    logic [31:0] acc;
    logic [5:0]  lz;
    logic        sfx;
    logic [2:0]  cnt;
    logic [3:0]  idx;
    logic [5:0]  pbits;
    logic [5:0]  lbits;
    logic [1:0]  chroma;
    logic [4:0]  prof;
    logic [7:0]  lvl;
    logic [15:0] wid;
    logic [15:0] hgt;
    logic [15:0] luma;
    logic [2:0]  err;
    logic        fin;
    logic        pend;
  } parse_t;

  localparam parse_t PARSE_RESET = '0;

  // 0 marks an Exp-Golomb element
  function automatic logic [5:0] elem_width(input logic [5:0] pos, input logic [2:0] cnt);
    logic [5:0] w;
    w = 6'd0;
    case (pos)
      P_VPS:      w = 6'd4;
      P_MAXSUB:   w = 6'd3;
      P_NEST:     w = 6'd1;
      P_PTLHEAD:  w = 6'd3;
      P_PROFILE:  w = 6'd5;
      P_COMPAT:   w = 6'd32;
      P_FLAGS48:  w = 6'd48;
      P_LEVEL:    w = 6'd8;
      P_SUBFLAGS: w = 6'd2;
      P_RESERVED: w = {1'b0, 4'(4'd8 - {1'b0, cnt}), 1'b0};
      P_SUBPROFA: w = 6'd44;
      P_SUBPROFB: w = 6'd44;
      P_SUBLEVEL: w = 6'd8;
      P_SEP:      w = 6'd1;
      P_CONFFLAG: w = 6'd1;
      default:    w = 6'd0;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/hsps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsps_if
// Valid/ready channels for payload bytes in and parse results out.
// ----------------------------------------------------------------------------
interface hsps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hsps_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [4:0]  profile_idc;
  logic [7:0]  level_idc;
  logic [15:0] pic_width;
  logic [15:0] pic_height;
  modport source (output valid, output status, output profile_idc, output level_idc,
                  output pic_width, output pic_height, input ready);
  modport sink (input valid, input status, input profile_idc, input level_idc,
                input pic_width, input pic_height, output ready);
endinterface

// File: rtl/core/hsps_bit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsps_bit_unit
// Shared parse step: consumes one bit, or takes one element-skip step.
// ----------------------------------------------------------------------------
module hsps_bit_unit (
  input  hsps_pkg::parse_t cur,
  input  logic             resolve,
  input  logic             bit_in,
  output hsps_pkg::parse_t nxt
);

  logic [5:0]  w;
  logic [5:0]  fbl_inc;
  logic [31:0] acc_sh;
  logic [17:0] gsum;
  logic        done;
  logic [31:0] v;

  always_comb begin
    nxt     = cur;
    w       = hsps_pkg::elem_width(cur.pos, cur.cnt);
    fbl_inc = cur.fbl + 6'd1;
    acc_sh  = {cur.acc[30:0], bit_in};
    gsum    = 18'((18'd1 << cur.lz) - 18'd1) + {1'b0, acc_sh[16:0]};
    done    = 1'b0;
    v       = '0;
    if (resolve) begin
      nxt.pend = 1'b0;
      case (cur.pos)
        hsps_pkg::P_SUBFLAGS: begin
          if (cur.idx >= {1'b0, cur.cnt}) begin
            nxt.idx = 4'd0;
            nxt.pos = hsps_pkg::P_RESERVED;
            nxt.pend = 1'b1;
          end
        end
        hsps_pkg::P_RESERVED: begin
          if (cur.cnt == 3'd0) begin
            nxt.pos = hsps_pkg::P_SUBPROFA;
            nxt.pend = 1'b1;
          end
        end
        hsps_pkg::P_SUBPROFA: begin
          nxt.pend = 1'b1;
          if (cur.idx >= {1'b0, cur.cnt}) begin
            nxt.pos = hsps_pkg::P_SPSID;
          end else if (cur.idx[2:0] < 3'd6 && cur.pbits[cur.idx[2:0]]) begin
            nxt.pend = 1'b0;
          end else begin
            nxt.pos = hsps_pkg::P_SUBLEVEL;
          end
        end
        hsps_pkg::P_SUBLEVEL: begin
          if (!(cur.idx[2:0] < 3'd6 && cur.lbits[cur.idx[2:0]])) begin
            nxt.idx = cur.idx + 4'd1;
            nxt.pos = hsps_pkg::P_SUBPROFA;
            nxt.pend = 1'b1;
          end
        end
        hsps_pkg::P_SEP: begin
          if (cur.chroma != 2'd3) begin
            nxt.pos = hsps_pkg::P_WIDTH;
            nxt.pend = 1'b1;
          end
        end
        default: nxt.pend = 1'b0;
      endcase
    end else if (cur.err == hsps_pkg::ST_OK && !cur.fin) begin
      if (w != 6'd0) begin
        nxt.acc = acc_sh;
        nxt.fbl = fbl_inc;
        if (fbl_inc >= w) begin
          done = 1'b1;
          v = acc_sh;
        end
      end else if (!cur.sfx) begin
        if (!bit_in) begin
          nxt.lz = cur.lz + 6'd1;
          if (cur.lz + 6'd1 > hsps_pkg::MAX_PREFIX_ZEROS) nxt.err = hsps_pkg::ST_OVERSIZE;
        end else if (cur.lz == 6'd0) begin
          done = 1'b1;
        end else begin
          nxt.sfx = 1'b1;
          nxt.acc = '0;
          nxt.fbl = 6'd0;
        end
      end else begin
        nxt.acc = acc_sh;
        nxt.fbl = fbl_inc;
        if (fbl_inc >= cur.lz) begin
          if (gsum > 18'd65535) nxt.err = hsps_pkg::ST_OVERSIZE;
          else begin
            done = 1'b1;
            v = {14'd0, gsum};
          end
        end
      end
    end

    if (done) begin
      nxt.pos  = cur.pos + 6'd1;
      nxt.pend = 1'b1;
      nxt.fbl  = 6'd0;
      nxt.acc  = '0;
      nxt.lz   = 6'd0;
      nxt.sfx  = 1'b0;
      case (cur.pos)
        hsps_pkg::P_MAXSUB: begin
          if (v > 32'(hsps_pkg::MAX_SUB_LAYERS)) begin
            nxt.err = hsps_pkg::ST_SUBLAYERS;
          end else begin
            nxt.cnt = v[2:0];
            nxt.idx = 4'd0;
            nxt.pbits = 6'd0;
            nxt.lbits = 6'd0;
          end
        end
        hsps_pkg::P_PROFILE: nxt.prof = v[4:0];
        hsps_pkg::P_LEVEL:   nxt.lvl = v[7:0];
        hsps_pkg::P_SUBFLAGS: begin
          if (v[1] && cur.idx[2:0] < 3'd6) nxt.pbits[cur.idx[2:0]] = 1'b1;
          if (v[0] && cur.idx[2:0] < 3'd6) nxt.lbits[cur.idx[2:0]] = 1'b1;
          nxt.idx = cur.idx + 4'd1;
          nxt.pos = hsps_pkg::P_SUBFLAGS;
        end
        hsps_pkg::P_SUBLEVEL: begin
          nxt.idx = cur.idx + 4'd1;
          nxt.pos = hsps_pkg::P_SUBPROFA;
        end
        hsps_pkg::P_SPSID: begin
          if (v > 32'(hsps_pkg::MAX_SPS_ID)) nxt.err = hsps_pkg::ST_SPSID;
        end
        hsps_pkg::P_CHROMA: begin
          if (v > 32'(hsps_pkg::MAX_CHROMA)) nxt.err = hsps_pkg::ST_CHROMA;
          else nxt.chroma = v[1:0];
        end
        hsps_pkg::P_WIDTH:    nxt.wid = v[15:0];
        hsps_pkg::P_HEIGHT:   nxt.hgt = v[15:0];
        hsps_pkg::P_CONFFLAG: nxt.pos = v[0] ? hsps_pkg::P_CONF0 : hsps_pkg::P_DEPTHL;
        hsps_pkg::P_DEPTHL:   nxt.luma = v[15:0];
        hsps_pkg::P_DEPTHC: begin
          nxt.pend = 1'b0;
          if (v[15:0] != cur.luma) nxt.err = hsps_pkg::ST_DEPTH;
          else nxt.fin = 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/hevc_sps_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevc_sps_header_parser
// SPS payload parser: fixed fields and ue(v) codes, one bit per cycle while no skip step is pending.
// ----------------------------------------------------------------------------
// Each byte is taken in the idle state, the only state in which in_if.ready is
// high. Its 8 bits then go through a single shared bit unit, one bit a cycle
// while no skip step is pending. Each completed syntax element is followed by a
// resolve step, and each skipped element or absent sub-layer entry takes one more.
// An emulation-prevention byte (03 after 00 00) is dropped in the idle state and
// never reaches the bit unit. The byte flagged last_byte is followed by a report
// state, held for as long as the previous result beat is still waiting, that
// produces one result beat with the status and the captured profile, level,
// width and height; the parser then resets for the next payload.
module hevc_sps_header_parser (
  input logic        clk,
  input logic        rst_n,
  hsps_in_if.sink    in_if,
  hsps_out_if.source out_if
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_BITS   = 2'd1;
  localparam logic [1:0] S_REPORT = 2'd2;

  logic [1:0]       st_r, st_nxt;
  hsps_pkg::parse_t ps_r, ps_nxt, unit_nxt;
  logic [7:0]       sh_r, sh_nxt;
  logic [2:0]       bc_r, bc_nxt;
  logic             last_r, last_nxt;
  logic [4:0]       byte_cnt_r, byte_cnt_nxt;
  logic [1:0]       zrun_r, zrun_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       status_r, status_nxt;
  logic [4:0]       prof_r, prof_nxt;
  logic [7:0]       lvl_r, lvl_nxt;
  logic [15:0]      wid_r, wid_nxt;
  logic [15:0]      hgt_r, hgt_nxt;
  logic             acc_beat;

  hsps_bit_unit u_unit (
    .cur     (ps_r),
    .resolve (ps_r.pend),
    .bit_in  (sh_r[7]),
    .nxt     (unit_nxt)
  );

  assign in_if.ready        = (st_r == S_IDLE);
  assign acc_beat           = in_if.valid && in_if.ready;
  assign out_if.valid       = out_valid_r;
  assign out_if.status      = status_r;
  assign out_if.profile_idc = prof_r;
  assign out_if.level_idc   = lvl_r;
  assign out_if.pic_width   = wid_r;
  assign out_if.pic_height  = hgt_r;

  always_comb begin
    st_nxt        = st_r;
    ps_nxt        = ps_r;
    sh_nxt        = sh_r;
    bc_nxt        = bc_r;
    last_nxt      = last_r;
    byte_cnt_nxt  = byte_cnt_r;
    zrun_nxt      = zrun_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    status_nxt    = status_r;
    prof_nxt      = prof_r;
    lvl_nxt       = lvl_r;
    wid_nxt       = wid_r;
    hgt_nxt       = hgt_r;
    case (st_r)
      S_IDLE: begin
        if (acc_beat) begin
          if (byte_cnt_r < hsps_pkg::MIN_BYTES) byte_cnt_nxt = byte_cnt_r + 5'd1;
          if (zrun_r == 2'd2 && in_if.data_byte == 8'h03) begin
            zrun_nxt = 2'd0;
            st_nxt = in_if.last_byte ? S_REPORT : S_IDLE;
          end else begin
            if (in_if.data_byte != 8'h00) zrun_nxt = 2'd0;
            else if (zrun_r != 2'd2) zrun_nxt = zrun_r + 2'd1;
            sh_nxt = in_if.data_byte;
            bc_nxt = 3'd0;
            last_nxt = in_if.last_byte;
            st_nxt = S_BITS;
          end
        end
      end
      S_BITS: begin
        ps_nxt = unit_nxt;
        if (!ps_r.pend) begin
          sh_nxt = {sh_r[6:0], 1'b0};
          bc_nxt = bc_r + 3'd1;
          if (bc_r == 3'd7) st_nxt = last_r ? S_REPORT : S_IDLE;
        end
      end
      S_REPORT: begin
        if (!out_valid_r || out_if.ready) begin
          if (byte_cnt_r < hsps_pkg::MIN_BYTES) status_nxt = hsps_pkg::ST_SHORT;
          else if (ps_r.err != hsps_pkg::ST_OK) status_nxt = ps_r.err;
          else if (ps_r.fin) status_nxt = hsps_pkg::ST_OK;
          else status_nxt = hsps_pkg::ST_TRUNC;
          prof_nxt      = ps_r.prof;
          lvl_nxt       = ps_r.lvl;
          wid_nxt       = ps_r.wid;
          hgt_nxt       = ps_r.hgt;
          out_valid_nxt = 1'b1;
          ps_nxt        = hsps_pkg::PARSE_RESET;
          byte_cnt_nxt  = 5'd0;
          zrun_nxt      = 2'd0;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      ps_r        <= hsps_pkg::PARSE_RESET;
      byte_cnt_r  <= 5'd0;
      zrun_r      <= 2'd0;
      out_valid_r <= 1'b0;
      bc_r        <= 3'd0;
      last_r      <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ps_r        <= ps_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      zrun_r      <= zrun_nxt;
      out_valid_r <= out_valid_nxt;
      bc_r        <= bc_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r     <= sh_nxt;
    status_r <= status_nxt;
    prof_r   <= prof_nxt;
    lvl_r    <= lvl_nxt;
    wid_r    <= wid_nxt;
    hgt_r    <= hgt_nxt;
  end

endmodule

// File: bench/hsps_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsps_tb_if
// Bench-side copy point for the parser channels; the RTL interfaces are used
// directly, so this file only holds shared bench constants.
// ----------------------------------------------------------------------------
package hsps_tb_pkg;
  localparam int BENCH_CYCLE_LIMIT = 2000000;
endpackage

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds SPS payloads (directed edge cases, then random well-formed and broken
// payloads) into the parser, predicts each status beat with a bit-level model
// and compares every result beat field by field.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  prof;
    logic [7:0]  lvl;
    logic [15:0] wid;
    logic [15:0] hgt;
  } sps_result_t;

  logic clk;
  logic rst_n;
  hsps_in_if  in_if ();
  hsps_out_if out_if ();

  hevc_sps_header_parser i_dut (.clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if));

  sps_result_t expected_sps[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off;

  // parser model state
  logic [5:0]  m_pos;
  int unsigned m_fbl;
  logic [31:0] m_acc;
  int unsigned m_lz;
  bit          m_sfx;
  int unsigned m_cnt, m_idx;
  logic [7:0]  m_pbits, m_lbits;
  logic [1:0]  m_chroma;
  int unsigned m_bytes, m_zeros;
  logic [4:0]  m_prof;
  logic [7:0]  m_lvl;
  logic [15:0] m_wid, m_hgt, m_luma;
  logic [2:0]  m_err;
  bit          m_fin;

  logic [7:0] pay[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > hsps_tb_pkg::BENCH_CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int unsigned field_width(logic [5:0] p);
    case (p)
      hsps_pkg::P_VPS: return 4;
      hsps_pkg::P_MAXSUB: return 3;
      hsps_pkg::P_NEST: return 1;
      hsps_pkg::P_PTLHEAD: return 3;
      hsps_pkg::P_PROFILE: return 5;
      hsps_pkg::P_COMPAT: return 32;
      hsps_pkg::P_FLAGS48: return 48;
      hsps_pkg::P_LEVEL: return 8;
      hsps_pkg::P_SUBFLAGS: return 2;
      hsps_pkg::P_RESERVED: return (8 - (m_cnt & 7)) * 2;
      hsps_pkg::P_SUBPROFA, hsps_pkg::P_SUBPROFB: return 44;
      hsps_pkg::P_SUBLEVEL: return 8;
      hsps_pkg::P_SEP, hsps_pkg::P_CONFFLAG: return 1;
      default: return 0;
    endcase
  endfunction

  task automatic enter_element(logic [5:0] p);
    bit found;
    found = 0;
    while (!found) begin
      case (p)
        hsps_pkg::P_SUBFLAGS: begin
          if (m_idx < m_cnt) found = 1;
          else begin m_idx = 0; p = hsps_pkg::P_RESERVED; end
        end
        hsps_pkg::P_RESERVED: if (m_cnt != 0) found = 1; else p = hsps_pkg::P_SUBPROFA;
        hsps_pkg::P_SUBPROFA: begin
          if (m_idx >= m_cnt) p = hsps_pkg::P_SPSID;
          else if (m_pbits[m_idx & 7]) found = 1;
          else p = hsps_pkg::P_SUBLEVEL;
        end
        hsps_pkg::P_SUBLEVEL: begin
          if (m_lbits[m_idx & 7]) found = 1;
          else begin m_idx = (m_idx + 1) & 15; p = hsps_pkg::P_SUBPROFA; end
        end
        hsps_pkg::P_SEP: if (m_chroma == 3) found = 1; else p = hsps_pkg::P_WIDTH;
        default: found = 1;
      endcase
    end
    m_pos = p; m_fbl = 0; m_acc = 0; m_lz = 0; m_sfx = 0;
  endtask

  task automatic clear_parser();
    m_cnt = 0; m_idx = 0; m_pbits = 0; m_lbits = 0; m_chroma = 0;
    m_bytes = 0; m_zeros = 0; m_prof = 0; m_lvl = 0; m_wid = 0; m_hgt = 0;
    m_luma = 0; m_err = hsps_pkg::ST_OK; m_fin = 0;
    enter_element(hsps_pkg::P_VPS);
  endtask

  task automatic finish_element(logic [31:0] v);
    logic [5:0] p;
    int unsigned i;
    p = m_pos;
    i = m_idx & 7;
    case (p)
      hsps_pkg::P_MAXSUB: begin
        if (v > hsps_pkg::MAX_SUB_LAYERS) begin m_err = hsps_pkg::ST_SUBLAYERS; return; end
        m_cnt = v & 7; m_idx = 0; m_pbits = 0; m_lbits = 0;
      end
      hsps_pkg::P_PROFILE: m_prof = v[4:0];
      hsps_pkg::P_LEVEL: m_lvl = v[7:0];
      hsps_pkg::P_SUBFLAGS: begin
        if (v[1]) m_pbits[i] = 1;
        if (v[0]) m_lbits[i] = 1;
        m_pbits[7:6] = 0; m_lbits[7:6] = 0;
        m_idx = (m_idx + 1) & 15;
        enter_element(hsps_pkg::P_SUBFLAGS);
        return;
      end
      hsps_pkg::P_SUBLEVEL: begin
        m_idx = (m_idx + 1) & 15;
        enter_element(hsps_pkg::P_SUBPROFA);
        return;
      end
      hsps_pkg::P_SPSID: if (v > 15) begin m_err = hsps_pkg::ST_SPSID; return; end
      hsps_pkg::P_CHROMA: begin
        if (v > 3) begin m_err = hsps_pkg::ST_CHROMA; return; end
        m_chroma = v[1:0];
      end
      hsps_pkg::P_WIDTH: m_wid = v[15:0];
      hsps_pkg::P_HEIGHT: m_hgt = v[15:0];
      hsps_pkg::P_CONFFLAG: begin
        enter_element(v[0] ? hsps_pkg::P_CONF0 : hsps_pkg::P_DEPTHL);
        return;
      end
      hsps_pkg::P_DEPTHL: m_luma = v[15:0];
      hsps_pkg::P_DEPTHC: begin
        if (v != m_luma) m_err = hsps_pkg::ST_DEPTH; else m_fin = 1;
        return;
      end
      default: ;
    endcase
    enter_element(p + 6'd1);
  endtask

  task automatic parse_bit(bit b);
    int unsigned w;
    logic [31:0] v;
    if (m_err != hsps_pkg::ST_OK || m_fin) return;
    w = field_width(m_pos);
    if (w != 0) begin
      m_acc = {m_acc[30:0], b};
      m_fbl++;
      if (m_fbl >= w) finish_element(m_acc);
      return;
    end
    if (!m_sfx) begin
      if (!b) begin
        m_lz++;
        if (m_lz > 16) m_err = hsps_pkg::ST_OVERSIZE;
        return;
      end
      if (m_lz == 0) begin finish_element(0); return; end
      m_sfx = 1; m_acc = 0; m_fbl = 0;
      return;
    end
    m_acc = {m_acc[30:0], b};
    m_fbl++;
    if (m_fbl >= m_lz) begin
      v = ((32'd1 << m_lz) - 1) + m_acc;
      if (v > 65535) m_err = hsps_pkg::ST_OVERSIZE; else finish_element(v);
    end
  endtask

  task automatic predict_sps_byte(logic [7:0] d, bit last);
    sps_result_t r;
    if (m_bytes < 20) m_bytes++;
    if (m_zeros == 2 && d == 8'h03) m_zeros = 0;
    else begin
      m_zeros = (d == 0) ? ((m_zeros < 2) ? m_zeros + 1 : 2) : 0;
      for (int k = 7; k >= 0; k--) parse_bit(d[k]);
    end
    if (!last) return;
    if (m_bytes < 20) r.status = hsps_pkg::ST_SHORT;
    else if (m_err != hsps_pkg::ST_OK) r.status = m_err;
    else if (m_fin) r.status = hsps_pkg::ST_OK;
    else r.status = hsps_pkg::ST_TRUNC;
    r.prof = m_prof; r.lvl = m_lvl; r.wid = m_wid; r.hgt = m_hgt;
    expected_sps.push_back(r);
    clear_parser();
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic send_beat(logic [7:0] d, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 0;
      @(posedge clk);
    end
    in_if.valid <= 1;
    in_if.data_byte <= d;
    in_if.last_byte <= last;
    predict_sps_byte(d, last);
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic send_payload();
    foreach (pay[i]) send_beat(pay[i], i == pay.size() - 1);
    pay.delete();
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_if.ready <= 0;
    else out_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    sps_result_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_sps.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        e = expected_sps.pop_front();
        if (out_if.status !== e.status) report_mismatch("status", out_if.status, e.status);
        if (out_if.profile_idc !== e.prof) report_mismatch("profile", out_if.profile_idc, e.prof);
        if (out_if.level_idc !== e.lvl) report_mismatch("level", out_if.level_idc, e.lvl);
        if (out_if.pic_width !== e.wid) report_mismatch("width", out_if.pic_width, e.wid);
        if (out_if.pic_height !== e.hgt) report_mismatch("height", out_if.pic_height, e.hgt);
      end
    end
  end

  // bit writer for payload construction
  logic [7:0] cur;
  int nbits;

  task automatic put_bits(logic [63:0] v, int n);
    for (int k = n - 1; k >= 0; k--) begin
      cur = {cur[6:0], v[k]};
      nbits++;
      if (nbits == 8) begin
        pay.push_back(cur);
        nbits = 0;
      end
    end
  endtask

  task automatic put_ue(int unsigned v);
    int unsigned x, n;
    x = v + 1; n = 0;
    while ((x >> (n + 1)) != 0) n++;
    put_bits(0, n);
    put_bits(x, n + 1);
  endtask

  // kind: 0 good, 1 sublayers, 2 sps id, 3 chroma, 4 depth, 5 oversize
  task automatic build_sps(int kind, int sub, int unsigned w, int unsigned h, bit rnd_tail);
    cur = 0; nbits = 0;
    put_bits($urandom_range(15), 4);
    put_bits(kind == 1 ? 7 : sub, 3);
    put_bits($urandom_range(1), 1);
    put_bits($urandom_range(7), 3);
    put_bits($urandom_range(31), 5);
    put_bits({$urandom, $urandom}, 32);
    put_bits({$urandom, $urandom}, 48);
    put_bits($urandom_range(255), 8);
    if (kind != 1) begin
      int pb[8], lb[8];
      for (int i = 0; i < sub; i++) begin
        pb[i] = $urandom_range(1); lb[i] = $urandom_range(1);
        put_bits({pb[i][0], lb[i][0]}, 2);
      end
      if (sub != 0) put_bits(0, (8 - sub) * 2);
      for (int i = 0; i < sub; i++) begin
        if (pb[i]) begin put_bits({$urandom, $urandom}, 44); put_bits({$urandom, $urandom}, 44); end
        if (lb[i]) put_bits($urandom_range(255), 8);
      end
      put_ue(kind == 2 ? $urandom_range(16, 200) : $urandom_range(15));
      begin
        int c;
        c = kind == 3 ? $urandom_range(4, 40) : $urandom_range(3);
        put_ue(c);
        if (c == 3) put_bits($urandom_range(1), 1);
      end
      if (kind == 5) put_ue(65535 + $urandom_range(1, 9));
      else begin
        int unsigned dl;
        put_ue(w); put_ue(h);
        if ($urandom_range(1)) begin
          put_bits(1, 1);
          repeat (4) put_ue($urandom_range(40));
        end else put_bits(0, 1);
        dl = $urandom_range(8);
        put_ue(dl);
        put_ue(kind == 4 ? dl + 1 : dl);
      end
    end
    put_bits(1, 1);
    if (nbits != 0) put_bits(0, 8 - nbits);
    while (pay.size() < 20 || rnd_tail && $urandom_range(3) != 0)
      pay.push_back($urandom_range(1, 255));
  endtask

  task automatic wait_drained();
    in_if.valid <= 0;
    while (expected_sps.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic test_directed();
    build_sps(0, 0, 1920, 1080, 0); send_payload();
    build_sps(0, 6, 65535, 0, 0); send_payload();
    build_sps(1, 0, 16, 16, 0); send_payload();
    build_sps(2, 2, 16, 16, 0); send_payload();
    build_sps(3, 1, 16, 16, 0); send_payload();
    build_sps(4, 3, 64, 64, 0); send_payload();
    build_sps(5, 0, 0, 0, 0); send_payload();
    // short payload, single byte
    pay.push_back(8'hFF); send_payload();
    // all zeros: long Exp-Golomb prefix and emulation bytes
    repeat (24) pay.push_back(8'h00); pay.push_back(8'h03); send_payload();
    repeat (3) pay.push_back(8'h00); pay.push_back(8'h03); pay.push_back(8'h03);
    repeat (20) pay.push_back(8'hFF); send_payload();
    // truncated: header only
    build_sps(0, 0, 100, 100, 0);
    while (pay.size() > 20) void'(pay.pop_back());
    pay[19] = 8'h80; send_payload();
    wait_drained();
  endtask

  task automatic test_random(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      int r;
      r = $urandom_range(99);
      if (r < 70) build_sps(0, $urandom_range(6),
                            $urandom_range(1) ? $urandom_range(65535) : $urandom_range(4096),
                            $urandom_range(1) ? $urandom_range(65535) : $urandom_range(4096), 1);
      else if (r < 85) build_sps($urandom_range(1, 5), $urandom_range(6), 32, 32, 0);
      else begin
        int len;
        len = $urandom_range(1, 40);
        repeat (len) pay.push_back($urandom_range(3) == 0 ? $urandom_range(3) : $urandom_range(255));
        if ($urandom_range(1)) while (pay.size() > 5) void'(pay.pop_back());
      end
      sent += pay.size();
      send_payload();
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    fork
      begin repeat (3000) @(posedge clk); hold_off = 0; end
      repeat (4) begin build_sps(0, 1, 8, 8, 0); send_payload(); end
    join
    wait_drained();
    build_sps(0, 2, 640, 480, 0);
    send_payload();
    wait_drained();
  endtask

  initial begin
    hold_off = 0;
    send_idle_pct = 37; recv_idle_pct = 70;
    in_if.valid = 0; in_if.data_byte = 0; in_if.last_byte = 0;
    rst_n = 0;
    clear_parser();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(400);
    send_idle_pct = 70; recv_idle_pct = 37;
    test_random(400);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(400);
    wait_drained();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
